// File: rtl/rewc_pkg.sv
// ----------------------------------------------------------------------------
// rewc_pkg: shared types and constants for the rotary encoder wrap counter
// Beat layouts, item kind codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rewc_pkg;

  // Item kind codes
  localparam logic [2:0] KIND_EDGE_A  = 3'd0;
  localparam logic [2:0] KIND_EDGE_B  = 3'd1;
  localparam logic [2:0] KIND_BUTTON  = 3'd2;
  localparam logic [2:0] KIND_LOAD    = 3'd3;
  localparam logic [2:0] KIND_RESTART = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_LOWER_BOUND     = 2'd0;
  localparam logic [1:0] REG_UPPER_BOUND     = 2'd1;
  localparam logic [1:0] REG_STEPS_PER_COUNT = 2'd2;

  // Register reset values
  localparam logic signed [15:0] LOWER_BOUND_RESET     = 16'sd0;
  localparam logic signed [15:0] UPPER_BOUND_RESET     = 16'sd255;
  localparam logic [6:0]         STEPS_PER_COUNT_RESET = 7'd7;

  // Input beat
  typedef struct packed {
    logic [2:0]         kind;
    logic               level;
    logic signed [15:0] new_value;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic signed [15:0] count;
    logic               pressed;
    logic               released;
  } out_item_t;

endpackage

// File: rtl/rotary_encoder_wrap_counter.sv
// ----------------------------------------------------------------------------
// rotary_encoder_wrap_counter: quadrature encoder counter with push button
// Counts encoder edges into a wrapping bounded value and tracks a button.
// ----------------------------------------------------------------------------
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one event per beat:
//   an edge on A or B with the sampled pin level, a raw button sample
//   (active low), a load request or a restart. Every input beat yields
//   exactly one output beat (out_valid/out_ready/out_data) with the count,
//   the pressed level and a one-shot released flag.
//   The result of an accepted beat is registered in the output register at
//   the edge that accepts it. Throughput is one beat per cycle while the
//   receiver does not stall; the update of count, step accumulator and pin
//   levels is combinational between the state and output registers.
//   The output register holds a waiting result while the receiver stalls;
//   in_ready stays high as long as the output register is free or is
//   being emptied in the same cycle.
//   Configuration is written through cfg_write/cfg_index/cfg_data while
//   idle; writes change only the registers, not count or accumulator.
//   Synchronous reset clears count, accumulator, pin levels and button
//   state, loads register defaults and empties the output register.
//
module rotary_encoder_wrap_counter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rewc_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rewc_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Configuration registers
  logic signed [15:0] lower_bound;
  logic signed [15:0] upper_bound;
  logic [6:0]         steps_per_count;

  // Block state
  logic signed [15:0] count_value;
  logic signed [7:0]  step_acc;
  logic               prev_a;
  logic               latest_b;
  logic               button_down;

  // Next state
  logic signed [15:0] count_value_next;
  logic signed [7:0]  step_acc_next;
  logic               prev_a_next;
  logic               latest_b_next;
  logic               button_down_next;
  logic               released_next;

  // Step arithmetic
  logic               in_fire;
  logic               step_dir;
  logic               is_edge;
  logic signed [7:0]  steps_s;
  logic signed [7:0]  acc_step;
  logic signed [7:0]  acc_mid;
  logic signed [16:0] cnt_ext;
  logic signed [16:0] cnt_mid;
  logic signed [16:0] cnt_moved;
  logic signed [16:0] cnt_wrap;
  logic signed [16:0] lower_ext;
  logic signed [16:0] upper_ext;
  logic               ge_hit;
  logic               le_hit;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound     <= rewc_pkg::LOWER_BOUND_RESET;
      upper_bound     <= rewc_pkg::UPPER_BOUND_RESET;
      steps_per_count <= rewc_pkg::STEPS_PER_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rewc_pkg::REG_LOWER_BOUND:     lower_bound     <= cfg_data;
        rewc_pkg::REG_UPPER_BOUND:     upper_bound     <= cfg_data;
        rewc_pkg::REG_STEPS_PER_COUNT: steps_per_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Take one edge step: accumulate, move count, wrap at the bounds
  always_comb begin
    is_edge   = (in_data.kind == rewc_pkg::KIND_EDGE_A) ||
                (in_data.kind == rewc_pkg::KIND_EDGE_B);
    step_dir  = ((in_data.kind == rewc_pkg::KIND_EDGE_B) ? in_data.level : latest_b) ^ prev_a;
    steps_s   = signed'({1'b0, steps_per_count});
    acc_step  = step_dir ? (step_acc + 8'sd1) : (step_acc - 8'sd1);
    cnt_ext   = {count_value[15], count_value};
    lower_ext = {lower_bound[15], lower_bound};
    upper_ext = {upper_bound[15], upper_bound};

    ge_hit    = (acc_step >= steps_s);
    acc_mid   = ge_hit ? 8'sd0 : acc_step;
    cnt_mid   = ge_hit ? (cnt_ext + 17'sd1) : cnt_ext;
    le_hit    = (acc_mid <= -steps_s);
    cnt_moved = le_hit ? (cnt_mid - 17'sd1) : cnt_mid;

    cnt_wrap  = (cnt_moved > upper_ext) ? lower_ext : cnt_moved;
    if (cnt_wrap < lower_ext) begin
      cnt_wrap = upper_ext;
    end
  end

  // Select the next state by item kind
  always_comb begin
    count_value_next = count_value;
    step_acc_next    = step_acc;
    prev_a_next      = prev_a;
    latest_b_next    = latest_b;
    button_down_next = button_down;
    released_next    = 1'b0;
    case (in_data.kind)
      rewc_pkg::KIND_EDGE_A, rewc_pkg::KIND_EDGE_B: begin
        count_value_next = cnt_wrap[15:0];
        step_acc_next    = le_hit ? 8'sd0 : acc_mid;
        if (in_data.kind == rewc_pkg::KIND_EDGE_A) begin
          prev_a_next = in_data.level;
        end else begin
          latest_b_next = in_data.level;
        end
      end
      rewc_pkg::KIND_BUTTON: begin
        button_down_next = !in_data.level;
        released_next    = button_down && in_data.level;
      end
      rewc_pkg::KIND_LOAD: begin
        if ((in_data.new_value <= upper_bound) && (in_data.new_value >= lower_bound)) begin
          count_value_next = in_data.new_value;
        end
      end
      rewc_pkg::KIND_RESTART: begin
        count_value_next = lower_bound;
        step_acc_next    = 8'sd0;
      end
      default: ;
    endcase
  end

  // Advance state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      count_value <= 16'sd0;
      step_acc    <= 8'sd0;
      prev_a      <= 1'b0;
      latest_b    <= 1'b0;
      button_down <= 1'b0;
    end else if (in_fire) begin
      count_value <= count_value_next;
      step_acc    <= step_acc_next;
      prev_a      <= prev_a_next;
      latest_b    <= latest_b_next;
      button_down <= button_down_next;
    end
  end

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.count    <= count_value_next;
      out_data.pressed  <= button_down_next;
      out_data.released <= released_next;
    end
  end

`ifndef SYNTHESIS
  // Every accepted beat shows a result in the next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

  // Restart puts count at the lower bound and clears the accumulator
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_data.kind == rewc_pkg::KIND_RESTART) |=>
      (out_data.count == $past(lower_bound)) && (step_acc == 8'sd0))
    else $error("restart did not reach lower bound");

  // After an edge with ordered bounds the count lies within them
  a_edge_in_bounds: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_edge && (lower_bound <= upper_bound) |=>
      (out_data.count >= $past(lower_bound)) && (out_data.count <= $past(upper_bound)))
    else $error("count outside bounds after edge");

  // A release beat never reports the button as held
  a_release_not_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.released |-> !out_data.pressed)
    else $error("released flagged while pressed");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the rotary encoder wrap counter
// Feeds encoder edges, button samples, loads and restarts over the input
// channel and checks every output beat against a cycle-free predictor of the
// count, step accumulator, pin levels and button state. A short scripted
// sequence comes first, then random phases under several register settings
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;

  // Spare kind code; the block must leave its state alone for it
  localparam logic [2:0] KIND_SPARE = 3'd7;
  localparam int         PHASES     = 8;
  localparam int         PHASE_BEATS = 100;

  typedef struct {
    rewc_pkg::in_item_t  beat;
    bit                  typed;
    rewc_pkg::out_item_t want;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  rewc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  rewc_pkg::out_item_t out_data;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  // Predictor state and register copies, at reset values
  int cnt_model   = 0;
  int acc_model   = 0;
  bit pin_a       = 1'b0;
  bit pin_b       = 1'b0;
  bit btn_down    = 1'b0;
  int lo_reg      = int'(rewc_pkg::LOWER_BOUND_RESET);
  int hi_reg      = int'(rewc_pkg::UPPER_BOUND_RESET);
  int steps_reg   = int'(rewc_pkg::STEPS_PER_COUNT_RESET);

  rewc_pkg::out_item_t awaited_reports [$];
  rewc_pkg::out_item_t head;
  int        errors = 0;
  int        counted_beats = 0;
  bit        calm = 1'b0;

  // Scripted opening: button, loads at and past the bounds, spare kind,
  // restart, then seven down steps (wrap below) and seven up steps (wrap above)
  plan_row_t script [24] = '{
    '{'{rewc_pkg::KIND_BUTTON,  1'b1, 16'sd0},    1'b1, '{16'sd0,   1'b0, 1'b0}},
    '{'{rewc_pkg::KIND_BUTTON,  1'b0, 16'sd0},    1'b1, '{16'sd0,   1'b1, 1'b0}},
    '{'{rewc_pkg::KIND_BUTTON,  1'b1, 16'sd0},    1'b1, '{16'sd0,   1'b0, 1'b1}},
    '{'{rewc_pkg::KIND_LOAD,    1'b0, 16'sd255},  1'b1, '{16'sd255, 1'b0, 1'b0}},
    '{'{rewc_pkg::KIND_LOAD,    1'b1, 16'sd256},  1'b1, '{16'sd255, 1'b0, 1'b0}},
    '{'{rewc_pkg::KIND_LOAD,    1'b0, 16'sh8000}, 1'b1, '{16'sd255, 1'b0, 1'b0}},
    '{'{rewc_pkg::KIND_LOAD,    1'b0, 16'sh7fff}, 1'b1, '{16'sd255, 1'b0, 1'b0}},
    '{'{rewc_pkg::KIND_LOAD,    1'b0, 16'sd200},  1'b1, '{16'sd200, 1'b0, 1'b0}},
    '{'{KIND_SPARE,             1'b1, 16'shffff}, 1'b1, '{16'sd200, 1'b0, 1'b0}},
    '{'{rewc_pkg::KIND_RESTART, 1'b1, 16'sd77},   1'b1, '{16'sd0,   1'b0, 1'b0}},
    '{'{rewc_pkg::KIND_EDGE_A,  1'b0, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_A,  1'b0, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_A,  1'b0, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_A,  1'b0, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_A,  1'b0, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_A,  1'b0, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_A,  1'b0, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_B,  1'b1, 16'sh5555}, 1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_B,  1'b1, 16'shaaaa}, 1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_B,  1'b1, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_B,  1'b1, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_B,  1'b1, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_B,  1'b1, 16'sd0},    1'b0, '0},
    '{'{rewc_pkg::KIND_EDGE_B,  1'b1, 16'sd0},    1'b0, '0}
  };

  rotary_encoder_wrap_counter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the step accumulator by one edge, then move and wrap the count
  function void step_once();
    if (pin_b ^ pin_a) acc_model++;
    else acc_model--;
    if (acc_model >= steps_reg) begin
      cnt_model++;
      acc_model = 0;
    end
    if (acc_model <= -steps_reg) begin
      cnt_model--;
      acc_model = 0;
    end
    if (cnt_model > hi_reg) cnt_model = lo_reg;
    if (cnt_model < lo_reg) cnt_model = hi_reg;
  endfunction

  // Work out the output beat that one accepted input beat yields
  function rewc_pkg::out_item_t encoder_outcome(rewc_pkg::in_item_t beat);
    rewc_pkg::out_item_t r;
    bit                  now_down;
    bit                  rel;
    rel = 1'b0;
    case (beat.kind)
      rewc_pkg::KIND_EDGE_A: begin
        step_once();
        pin_a = beat.level;
      end
      rewc_pkg::KIND_EDGE_B: begin
        pin_b = beat.level;
        step_once();
      end
      rewc_pkg::KIND_BUTTON: begin
        now_down = !beat.level;
        if (btn_down && !now_down) rel = 1'b1;
        btn_down = now_down;
      end
      rewc_pkg::KIND_LOAD: begin
        if (int'(beat.new_value) <= hi_reg && int'(beat.new_value) >= lo_reg)
          cnt_model = int'(beat.new_value);
      end
      rewc_pkg::KIND_RESTART: begin
        cnt_model = lo_reg;
        acc_model = 0;
      end
      default: ;
    endcase
    r.count    = 16'(cnt_model);
    r.pressed  = btn_down;
    r.released = rel;
    return r;
  endfunction

  function rewc_pkg::in_item_t beat_of(logic [2:0] kind, logic level, logic [15:0] nv);
    rewc_pkg::in_item_t b;
    b.kind      = kind;
    b.level     = level;
    b.new_value = nv;
    return b;
  endfunction

  // Offer one beat, hold it until taken, then queue what it should yield
  task automatic present(input rewc_pkg::in_item_t beat, input bit typed,
                         input rewc_pkg::out_item_t want);
    rewc_pkg::out_item_t guess;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = encoder_outcome(beat);
    awaited_reports.push_back(typed ? want : guess);
    if (beat.kind <= rewc_pkg::KIND_RESTART) counted_beats++;
  endtask

  task automatic offer(input logic [2:0] kind, input logic level, input logic [15:0] nv);
    present(beat_of(kind, level, nv), 1'b0, '0);
  endtask

  // Drop valid and wait until every queued result has drained
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_write after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      rewc_pkg::REG_LOWER_BOUND:     lo_reg = int'($signed(val));
      rewc_pkg::REG_UPPER_BOUND:     hi_reg = int'($signed(val));
      rewc_pkg::REG_STEPS_PER_COUNT: steps_reg = int'(val[6:0]);
      default: ;
    endcase
  endtask

  // One burst of random traffic: mostly clean rotation, some noise
  task automatic random_chunk();
    int          pick;
    int          n;
    int          v;
    bit          down_dir;
    logic [15:0] junk;
    pick = $urandom_range(0, 99);
    junk = 16'($urandom);
    if (pick < 55) begin
      n = $urandom_range(1, 24);
      down_dir = 1'($urandom_range(0, 1));
      repeat (n) begin
        junk = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          // bounce or out-of-order edge
          offer($urandom_range(0, 1) ? rewc_pkg::KIND_EDGE_B : rewc_pkg::KIND_EDGE_A,
                1'($urandom_range(0, 1)), junk);
        end else if (down_dir ? (pin_a == pin_b) : (pin_a != pin_b)) begin
          offer(rewc_pkg::KIND_EDGE_A, !pin_a, junk);
        end else begin
          offer(rewc_pkg::KIND_EDGE_B, !pin_b, junk);
        end
      end
    end else if (pick < 67) begin
      repeat ($urandom_range(1, 6))
        offer(rewc_pkg::KIND_BUTTON, 1'($urandom_range(0, 1)), junk);
    end else if (pick < 79) begin
      case ($urandom_range(0, 5))
        0: v = lo_reg;
        1: v = hi_reg;
        2: v = lo_reg - 1;
        3: v = hi_reg + 1;
        4: v = (lo_reg <= hi_reg) ? lo_reg + $urandom_range(0, hi_reg - lo_reg) : lo_reg;
        default: v = int'($signed(junk));
      endcase
      offer(rewc_pkg::KIND_LOAD, 1'($urandom_range(0, 1)), 16'(v));
    end else if (pick < 84) begin
      offer(rewc_pkg::KIND_RESTART, 1'($urandom_range(0, 1)), junk);
    end else begin
      offer(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), junk);
    end
  endtask

  // Stimulus: reset, scripted opening, then random phases
  initial begin
    logic [15:0] lo_val;
    logic [15:0] hi_val;
    logic [6:0]  steps_val;
    int          target;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = rewc_pkg::REG_LOWER_BOUND;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) present(script[i].beat, script[i].typed, script[i].want);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo_val = 16'hfffb; hi_val = 16'h0005; steps_val = 7'd1;   end
        1: begin lo_val = 16'h8000; hi_val = 16'h7fff; steps_val = 7'd1;   end
        2: begin lo_val = 16'h7ff8; hi_val = 16'h7fff; steps_val = 7'd3;   end
        3: begin lo_val = 16'h8000; hi_val = 16'h8008; steps_val = 7'd2;   end
        4: begin lo_val = 16'h000a; hi_val = 16'hfff6; steps_val = 7'd0;   end
        5: begin lo_val = 16'h0000; hi_val = 16'h0000; steps_val = 7'd127; end
        default: begin
          lo_val    = 16'($urandom);
          hi_val    = 16'($urandom);
          steps_val = 7'($urandom_range(0, 127));
        end
      endcase
      if (p == PHASES - 1) calm = 1'b1;
      drain();
      write_reg(rewc_pkg::REG_LOWER_BOUND, lo_val);
      write_reg(rewc_pkg::REG_UPPER_BOUND, hi_val);
      write_reg(rewc_pkg::REG_STEPS_PER_COUNT, {9'($urandom), steps_val});
      cfg_write <= 1'b0;
      target = counted_beats + PHASE_BEATS;
      while (counted_beats < target) random_chunk();
    end

    drain();
    repeat (5) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Output side: stall in random bursts, none in the calm tail
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 8) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each output beat against the oldest queued expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected output beat: count %0d", out_data.count);
        errors++;
      end else begin
        head = awaited_reports.pop_front();
        if (out_data.count !== head.count) begin
          $error("count: expected %0d, actual %0d", head.count, out_data.count);
          errors++;
        end
        if (out_data.pressed !== head.pressed) begin
          $error("pressed: expected %0b, actual %0b", head.pressed, out_data.pressed);
          errors++;
        end
        if (out_data.released !== head.released) begin
          $error("released: expected %0b, actual %0b", head.released, out_data.released);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
